// File: src/g726_pkg.sv
// Package for the 32 kbit/s ADPCM codec: state encoding, tables and the
// fixed-point helpers (log, antilog, float multiply). No dependencies.
package g726_pkg;

  localparam int ZeroTapsDefault = 6;
  localparam int StepUnlockedMin = 544;
  localparam int StepUnlockedMax = 5120;
  localparam int StepLockedReset = 34816;
  localparam int ToneA2Limit = -11776;
  localparam int A1Limit = 15360;
  localparam int A2Limit = 12288;
  localparam logic [15:0] FloatZero = 16'h0020;
  localparam logic [15:0] FloatNegZero = 16'hFC20;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_STEP, ST_QUANT, ST_RECON, ST_UPDATE, ST_OUT
  } state_t;

  function automatic int s16(input int x);
    logic [15:0] u;
    u = x[15:0];
    return int'(signed'(u));
  endfunction

  function automatic int log_count(input int v);
    int cnt;
    cnt = 0;
    for (int k = 0; k < 15; k++) begin
      if (v >= (1 << k)) cnt = k + 1;
    end
    return cnt;
  endfunction

  function automatic int dqln_lut(input logic [3:0] c);
    case (c)
      4'd0, 4'd15: return -2048;
      4'd1, 4'd14: return 4;
      4'd2, 4'd13: return 135;
      4'd3, 4'd12: return 213;
      4'd4, 4'd11: return 273;
      4'd5, 4'd10: return 323;
      4'd6, 4'd9:  return 373;
      default:     return 425;
    endcase
  endfunction

  function automatic int wi_lut(input logic [3:0] c);
    case (c)
      4'd0, 4'd15: return -12;
      4'd1, 4'd14: return 18;
      4'd2, 4'd13: return 41;
      4'd3, 4'd12: return 64;
      4'd4, 4'd11: return 112;
      4'd5, 4'd10: return 198;
      4'd6, 4'd9:  return 355;
      default:     return 1122;
    endcase
  endfunction

  function automatic int fi_lut(input logic [3:0] c);
    case (c)
      4'd3, 4'd4, 4'd5, 4'd10, 4'd11, 4'd12: return 32'h200;
      4'd6, 4'd9: return 32'h600;
      4'd7, 4'd8: return 32'hE00;
      default: return 0;
    endcase
  endfunction

  function automatic int bound_lut(input int i);
    case (i)
      0: return -124;
      1: return 80;
      2: return 178;
      3: return 246;
      4: return 300;
      5: return 349;
      default: return 400;
    endcase
  endfunction

  // Coefficient (linear) times history word (float), result in linear form.
  function automatic int float_mult(input int an, input int srn);
    int mag, ex, mant, wex, wmant, r;
    mag = (an > 0) ? an : ((-an) & 32'h1FFF);
    ex = log_count(mag) - 6;
    if (mag == 0) mant = 32;
    else if (ex >= 0) mant = mag >> ex;
    else mant = mag << (-ex);
    wex = ex + ((srn >>> 6) & 15) - 13;
    wmant = (mant * (srn & 63) + 32'h30) >>> 4;
    if (wex >= 0) r = (wmant << wex) & 32'h7FFF;
    else r = wmant >>> (-wex);
    return ((an < 0) != (srn < 0)) ? -r : r;
  endfunction

  function automatic int quantize(input int d, input int y);
    int dqm, ex, mant, dl, dln, i;
    dqm = s16((d < 0) ? -d : d);
    ex = log_count(dqm >>> 1);
    mant = ((dqm * 128) >>> ex) & 32'h7F;
    dl = s16(ex * 128 + mant);
    dln = s16(dl - (y >>> 2));
    i = 0;
    for (int k = 0; k < 7; k++) begin
      if (dln >= bound_lut(k)) i = k + 1;
    end
    if (d < 0) return 15 - i;
    return (i == 0) ? 15 : i;
  endfunction

  function automatic int reconstruct(input logic neg, input int dqln, input int y);
    int dql, dex, dqt, sh, v, dq;
    dql = s16(dqln + (y >>> 2));
    dex = (dql >>> 7) & 15;
    dqt = 128 + (dql & 127);
    sh = 14 - dex;
    v = (sh >= 0) ? ((dqt << 7) >>> sh) : ((dqt << 7) << 1);
    dq = s16(v);
    if (dql < 0) return neg ? -32768 : 0;
    return neg ? dq - 32768 : dq;
  endfunction

  function automatic int to_float(input int mag, input logic neg);
    int ex;
    ex = log_count(mag);
    return s16((ex << 6) + ((mag << 6) >>> ex) - (neg ? 32'h400 : 0));
  endfunction

endpackage

// File: src/g726_32k_adpcm_codec_unit.sv
// Top level of the 32 kbit/s ADPCM codec: sequencer, shared tap multiplier,
// predictor and quantizer state. Depends on g726_pkg.
//
// One item (a linear sample in encode mode, a 4-bit code in decode mode)
// yields one result item. The block handles one item at a time: it steps
// through each predictor tap on a single shared float multiplier
// (ZERO_TAPS zeros, then two poles), then through step size, quantize,
// reconstruct and state update, each in its own state. The result is held
// until taken; in_stall stays high from acceptance until the result is
// taken, so the next item is not accepted before then, and each output
// stall holds the block in its output state.
// encode_mode (reset 1) is written through cfg_valid/cfg_ready while idle.
// In encode mode pcm_out reads 0; in decode mode code_out reads 0.
module g726_32k_adpcm_codec_unit #(
  parameter int ZERO_TAPS = g726_pkg::ZeroTapsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] pcm_sample,
  input  logic        [3:0]  code_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [3:0]  code_out,
  output logic signed [15:0] pcm_out
);
  import g726_pkg::*;

  localparam int NumTaps = ZERO_TAPS + 2;
  localparam int TapW = $clog2(NumTaps);

  state_t state, state_next;
  logic [TapW-1:0] tap;

  logic encode_mode;
  logic [18:0] step_locked;
  logic [12:0] step_unlocked;
  logic signed [15:0] energy_short, energy_long;
  logic [9:0] speed_weight;
  logic signed [15:0] pole_coeffs [2];
  logic signed [15:0] zero_coeffs [ZERO_TAPS];
  logic sign_history [2];
  logic signed [15:0] diff_history [ZERO_TAPS];
  logic signed [15:0] recon_history [2];
  logic tone_flag;

  // per-item working registers
  logic signed [15:0] sample;
  logic [3:0] code;
  logic signed [18:0] zacc, pacc;
  logic signed [15:0] se, sez, y, dq, sr, dqsez;

  // shared tap multiplier operands
  int op_a, op_b, prod;
  always_comb begin
    if (int'(tap) < ZERO_TAPS) begin
      op_a = int'(zero_coeffs[tap[TapW-1:0]]) >>> 2;
      op_b = int'(diff_history[tap[TapW-1:0]]);
    end else if (int'(tap) == ZERO_TAPS) begin
      op_a = int'(pole_coeffs[1]) >>> 2;
      op_b = int'(recon_history[1]);
    end else begin
      op_a = int'(pole_coeffs[0]) >>> 2;
      op_b = int'(recon_history[0]);
    end
    prod = float_mult(op_a, op_b);
  end

  // estimate and step size
  int sezi, se_c, y_c, ylo, dif, al;
  always_comb begin
    sezi = s16(int'(zacc));
    if (encode_mode) se_c = s16((sezi + int'(pacc)) >>> 1);
    else se_c = s16(sezi + int'(pacc)) >>> 1;
    ylo = int'(step_locked >> 6);
    dif = int'(step_unlocked) - ylo;
    al = int'(speed_weight) >>> 2;
    if (speed_weight >= 10'd256) y_c = int'(step_unlocked);
    else if (dif > 0) y_c = ylo + ((dif * al) >>> 6);
    else if (dif < 0) y_c = ylo + ((dif * al + 32'h3F) >>> 6);
    else y_c = ylo;
  end

  int code_c;
  always_comb begin
    if (encode_mode) code_c = quantize(s16((int'(sample) >>> 2) - int'(se)), int'(y));
    else code_c = int'(code);
  end

  int dq_c, sr_c, dqsez_c;
  always_comb begin
    dq_c = s16(reconstruct(code[3], dqln_lut(code), int'(y)));
    sr_c = s16((dq_c < 0) ? int'(se) - (dq_c & 32'h3FFF) : int'(se) + dq_c);
    dqsez_c = s16(sr_c - int'(se) + int'(sez));
  end

  // state update
  logic pk0, pks1, tr, tone_n;
  int mag, ylint, ylfrac, thr1, thr2, dqthr, wi, fi, su_n, yl_n, a2p, fa1, a0, a1ul;
  int es_n, el_n, edif, sw_n, b;
  logic signed [15:0] zc_n [ZERO_TAPS];
  logic signed [15:0] dh0_n, rh0_n;
  always_comb begin
    pk0 = dqsez < 0;
    mag = int'(dq) & 32'h7FFF;
    ylint = int'(step_locked >> 15);
    ylfrac = int'((step_locked >> 10) & 19'h1F);
    thr1 = s16((32 + ylfrac) << ylint);
    thr2 = (ylint > 9) ? (31 << 10) : thr1;
    dqthr = s16((thr2 + (thr2 >>> 1)) >>> 1);
    tr = tone_flag && (mag > dqthr);
    wi = wi_lut(code) * 32;
    fi = fi_lut(code);

    su_n = s16(int'(y) + ((wi - int'(y)) >>> 5));
    if (su_n < StepUnlockedMin) su_n = StepUnlockedMin;
    else if (su_n > StepUnlockedMax) su_n = StepUnlockedMax;
    yl_n = int'(step_locked) + su_n + ((-int'(step_locked)) >>> 6);

    pks1 = pk0 ^ sign_history[0];
    a2p = s16(int'(pole_coeffs[1]) - (int'(pole_coeffs[1]) >>> 7));
    fa1 = s16(pks1 ? int'(pole_coeffs[0]) : -int'(pole_coeffs[0]));
    if (dqsez != 0) begin
      if (fa1 < -8191) a2p = s16(a2p - 32'h100);
      else if (fa1 > 8191) a2p = s16(a2p + 32'hFF);
      else a2p = s16(a2p + (fa1 >>> 5));
      if (pk0 ^ sign_history[1]) begin
        if (a2p <= -12160) a2p = -A2Limit;
        else if (a2p >= 12416) a2p = A2Limit;
        else a2p = a2p - 32'h80;
      end else begin
        if (a2p <= -12416) a2p = -A2Limit;
        else if (a2p >= 12160) a2p = A2Limit;
        else a2p = a2p + 32'h80;
      end
    end
    a0 = s16(int'(pole_coeffs[0]) - (int'(pole_coeffs[0]) >>> 8));
    if (dqsez != 0) a0 = s16(pks1 ? a0 - 192 : a0 + 192);
    a1ul = s16(A1Limit - a2p);
    if (a0 < -a1ul) a0 = s16(-a1ul);
    else if (a0 > a1ul) a0 = a1ul;
    if (tr) begin
      a2p = 0;
      a0 = 0;
    end

    for (int i = 0; i < ZERO_TAPS; i++) begin
      b = s16(int'(zero_coeffs[i]) - (int'(zero_coeffs[i]) >>> 8));
      if (mag != 0)
        b = s16(((dq < 0) == (diff_history[i] < 0)) ? b + 128 : b - 128);
      zc_n[i] = tr ? 16'sd0 : b[15:0];
    end

    if (mag == 0) dh0_n = (dq >= 0) ? FloatZero : FloatNegZero;
    else dh0_n = 16'(to_float(mag, dq < 0));

    if (sr == 0) rh0_n = FloatZero;
    else if (sr > 0) rh0_n = 16'(to_float(int'(sr), 1'b0));
    else if (int'(sr) > -32768) rh0_n = 16'(to_float(-int'(sr), 1'b1));
    else rh0_n = FloatNegZero;

    tone_n = !tr && (a2p < ToneA2Limit);
    es_n = s16(int'(energy_short) + ((fi - int'(energy_short)) >>> 5));
    el_n = s16(int'(energy_long) + ((fi * 4 - int'(energy_long)) >>> 7));
    edif = es_n * 4 - el_n;
    if (edif < 0) edif = -edif;
    if (tr) sw_n = 256;
    else if (y < 16'sd1536 || tone_n || edif >= (el_n >>> 3))
      sw_n = s16(int'(speed_weight) + ((32'h200 - int'(speed_weight)) >>> 4));
    else
      sw_n = s16(int'(speed_weight) + ((-int'(speed_weight)) >>> 4));
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MAC;
      ST_MAC:    if (int'(tap) == NumTaps - 1) state_next = ST_STEP;
      ST_STEP:   state_next = ST_QUANT;
      ST_QUANT:  state_next = ST_RECON;
      ST_RECON:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and predictor state
  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
      encode_mode <= 1'b1;
      step_locked <= 19'(StepLockedReset);
      step_unlocked <= 13'(StepUnlockedMin);
      energy_short <= '0;
      energy_long <= '0;
      speed_weight <= '0;
      tone_flag <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        pole_coeffs[i] <= '0;
        sign_history[i] <= 1'b0;
        recon_history[i] <= FloatZero;
      end
      for (int i = 0; i < ZERO_TAPS; i++) begin
        zero_coeffs[i] <= '0;
        diff_history[i] <= FloatZero;
      end
    end else begin
      if (cfg_valid && cfg_ready) encode_mode <= cfg_data;
      if (state == ST_MAC) tap <= tap + 1'b1;
      else tap <= '0;
      if (state == ST_UPDATE) begin
        step_unlocked <= su_n[12:0];
        step_locked <= yl_n[18:0];
        pole_coeffs[1] <= a2p[15:0];
        pole_coeffs[0] <= a0[15:0];
        for (int i = 0; i < ZERO_TAPS; i++) zero_coeffs[i] <= zc_n[i];
        for (int i = ZERO_TAPS - 1; i > 0; i--) diff_history[i] <= diff_history[i-1];
        diff_history[0] <= dh0_n;
        recon_history[1] <= recon_history[0];
        recon_history[0] <= rh0_n;
        sign_history[1] <= sign_history[0];
        sign_history[0] <= pk0;
        tone_flag <= tone_n;
        energy_short <= es_n[15:0];
        energy_long <= el_n[15:0];
        speed_weight <= sw_n[9:0];
      end
    end
  end

  // per-item datapath: latch the item, accumulate taps, advance the stages
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sample <= pcm_sample;
        code <= code_in;
        zacc <= '0;
        pacc <= '0;
      end
      ST_MAC: begin
        if (int'(tap) < ZERO_TAPS) zacc <= zacc + 19'(prod);
        else pacc <= pacc + 19'(prod);
      end
      ST_STEP: begin
        se <= se_c[15:0];
        sez <= 16'(sezi >>> 1);
        y <= y_c[15:0];
      end
      ST_QUANT: code <= code_c[3:0];
      ST_RECON: begin
        dq <= dq_c[15:0];
        sr <= sr_c[15:0];
        dqsez <= dqsez_c[15:0];
      end
      ST_UPDATE: begin
        code_out <= encode_mode ? code : 4'd0;
        pcm_out <= encode_mode ? 16'sd0 : {sr[13:0], 2'b00};
      end
      default: ;
    endcase
  end

endmodule

// File: test/tb_top.sv
// Self-checking bench for the 32 kbit/s ADPCM codec top level.
// Holds its own bit-exact model of the codec and compares every result item.
// Depends on g726_pkg and g726_32k_adpcm_codec_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] pcm_sample;
  logic        [3:0]  code_in;
  logic               out_valid;
  logic               out_stall;
  logic        [3:0]  code_out;
  logic signed [15:0] pcm_out;

  g726_32k_adpcm_codec_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pcm_sample(pcm_sample), .code_in(code_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .code_out(code_out), .pcm_out(pcm_out)
  );

  localparam int ZeroTaps = g726_pkg::ZeroTapsDefault;
  // Drain allowance after the last result: one item's full pass plus margin.
  localparam int SettleCycles = ZeroTaps + 6 + 8;

  typedef struct {
    logic [3:0]  code;
    logic [15:0] pcm;
  } codec_result_t;

  // Expected result items, oldest first.
  codec_result_t expected_results[$];

  int mismatch_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int enc_items = 0;
  int dec_items = 0;
  int mode_writes = 0;
  int burst_left = 0;

  // Codec tables.
  int quant_edge[7] = '{-124, 80, 178, 246, 300, 349, 400};
  int dq_log[16] = '{-2048, 4, 135, 213, 273, 323, 373, 425,
                     425, 373, 323, 273, 213, 135, 4, -2048};
  int scale_wt[16] = '{-12, 18, 41, 64, 112, 198, 355, 1122,
                       1122, 355, 198, 112, 64, 41, 18, -12};
  int rate_wt[16] = '{0, 0, 0, 'h200, 'h200, 'h200, 'h600, 'hE00,
                      'hE00, 'h600, 'h200, 'h200, 'h200, 0, 0, 0};

  // Model state.
  logic mdl_encode;
  int   mdl_yl;          // locked scale factor, 19 bits
  int   mdl_yu;          // unlocked scale factor
  int   mdl_dms, mdl_dml, mdl_ap;
  int   mdl_a[2];
  int   mdl_b[ZeroTaps];
  logic mdl_pk[2];
  int   mdl_dq[ZeroTaps];
  int   mdl_sr[2];
  logic mdl_td;

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int wrap16(input int x);
    logic [15:0] u;
    u = x[15:0];
    return int'($signed(u));
  endfunction

  // Count of powers of two (1 .. 16384) not above v.
  function automatic int pow_count(input int v);
    int n;
    n = 0;
    while (n < 15 && v >= (1 << n)) n++;
    return n;
  endfunction

  // Linear coefficient times history word in the small float format.
  function automatic int coef_times_hist(input int an, input int srn);
    int mag, ex, mant, wex, wmant, r;
    mag = (an > 0) ? an : ((-an) & 'h1FFF);
    ex = pow_count(mag) - 6;
    if (mag == 0) mant = 32;
    else if (ex >= 0) mant = mag >> ex;
    else mant = mag << (-ex);
    wex = ex + ((srn >>> 6) & 15) - 13;
    wmant = (mant * (srn & 63) + 'h30) >>> 4;
    r = (wex >= 0) ? ((wmant << wex) & 'h7FFF) : (wmant >>> (-wex));
    return ((an < 0) != (srn < 0)) ? -r : r;
  endfunction

  function automatic int lin_to_float(input int mag, input logic neg);
    int ex;
    ex = pow_count(mag);
    return wrap16((ex << 6) + ((mag << 6) >> ex) - (neg ? 'h400 : 0));
  endfunction

  function automatic int mixed_scale();
    int y, dif, al;
    if (mdl_ap >= 256) return mdl_yu;
    y = mdl_yl >> 6;
    dif = mdl_yu - y;
    al = mdl_ap >>> 2;
    if (dif > 0) y += (dif * al) >>> 6;
    else if (dif < 0) y += (dif * al + 'h3F) >>> 6;
    return y;
  endfunction

  function automatic int code_from_diff(input int d, input int y);
    int dqm, ex, mant, dl, dln, i;
    dqm = wrap16((d < 0) ? -d : d);
    ex = pow_count(dqm >>> 1);
    mant = ((dqm * 128) >>> ex) & 'h7F;
    dl = wrap16(ex * 128 + mant);
    dln = wrap16(dl - (y >>> 2));
    i = 0;
    while (i < 7 && dln >= quant_edge[i]) i++;
    if (d < 0) return 15 - i;
    return (i == 0) ? 15 : i;
  endfunction

  function automatic int diff_from_log(input logic neg, input int dqln, input int y);
    int dql, dex, dqt, sh, v, dq;
    dql = wrap16(dqln + (y >>> 2));
    if (dql < 0) return neg ? -32768 : 0;
    dex = (dql >> 7) & 15;
    dqt = 128 + (dql & 127);
    sh = 14 - dex;
    v = (sh >= 0) ? ((dqt << 7) >> sh) : ((dqt << 7) << 1);
    dq = wrap16(v);
    return neg ? dq - 32768 : dq;
  endfunction

  task automatic adapt_state(input int y, input int wi, input int fi, input int dq,
                             input int sr, input int dqsez);
    logic pk0, pks1, tr;
    int mag, ylint, ylfrac, thr1, thr2, dqthr, a2p, yl, fa1, a0, a1ul, b, dif;
    pk0 = (dqsez < 0);
    mag = dq & 'h7FFF;
    ylint = mdl_yl >> 15;
    ylfrac = (mdl_yl >> 10) & 'h1F;
    thr1 = wrap16((32 + ylfrac) << ylint);
    thr2 = (ylint > 9) ? (31 << 10) : thr1;
    dqthr = wrap16((thr2 + (thr2 >>> 1)) >> 1);
    tr = mdl_td && (mag > dqthr);
    a2p = 0;

    mdl_yu = wrap16(y + ((wi - y) >>> 5));
    if (mdl_yu < 544) mdl_yu = 544;
    else if (mdl_yu > 5120) mdl_yu = 5120;

    yl = mdl_yl;
    yl += mdl_yu + ((-yl) >>> 6);
    mdl_yl = yl & 'h7FFFF;

    if (tr) begin
      mdl_a[0] = 0;
      mdl_a[1] = 0;
      for (int i = 0; i < ZeroTaps; i++) mdl_b[i] = 0;
    end else begin
      pks1 = pk0 ^ mdl_pk[0];
      a2p = wrap16(mdl_a[1] - (mdl_a[1] >>> 7));
      if (dqsez != 0) begin
        fa1 = wrap16(pks1 ? mdl_a[0] : -mdl_a[0]);
        if (fa1 < -8191) a2p = wrap16(a2p - 'h100);
        else if (fa1 > 8191) a2p = wrap16(a2p + 'hFF);
        else a2p = wrap16(a2p + (fa1 >>> 5));
        if (pk0 ^ mdl_pk[1]) begin
          if (a2p <= -12160) a2p = -12288;
          else if (a2p >= 12416) a2p = 12288;
          else a2p -= 'h80;
        end else begin
          if (a2p <= -12416) a2p = -12288;
          else if (a2p >= 12160) a2p = 12288;
          else a2p += 'h80;
        end
      end
      mdl_a[1] = a2p;

      a0 = wrap16(mdl_a[0] - (mdl_a[0] >>> 8));
      if (dqsez != 0) a0 = wrap16(!pks1 ? a0 + 192 : a0 - 192);
      a1ul = wrap16(15360 - a2p);
      if (a0 < -a1ul) a0 = wrap16(-a1ul);
      else if (a0 > a1ul) a0 = a1ul;
      mdl_a[0] = a0;

      for (int i = 0; i < ZeroTaps; i++) begin
        b = wrap16(mdl_b[i] - (mdl_b[i] >>> 8));
        if (mag != 0) b = wrap16(((dq < 0) == (mdl_dq[i] < 0)) ? b + 128 : b - 128);
        mdl_b[i] = b;
      end
    end

    for (int i = ZeroTaps - 1; i > 0; i--) mdl_dq[i] = mdl_dq[i - 1];
    if (mag == 0) mdl_dq[0] = (dq >= 0) ? 'h20 : wrap16('hFC20);
    else mdl_dq[0] = lin_to_float(mag, dq < 0);

    mdl_sr[1] = mdl_sr[0];
    if (sr == 0) mdl_sr[0] = 'h20;
    else if (sr > 0) mdl_sr[0] = lin_to_float(sr, 1'b0);
    else if (sr > -32768) mdl_sr[0] = lin_to_float(-sr, 1'b1);
    else mdl_sr[0] = wrap16('hFC20);

    mdl_pk[1] = mdl_pk[0];
    mdl_pk[0] = pk0;

    mdl_td = (!tr && a2p < -11776);

    mdl_dms = wrap16(mdl_dms + ((fi - mdl_dms) >>> 5));
    mdl_dml = wrap16(mdl_dml + ((fi * 4 - mdl_dml) >>> 7));

    if (tr) begin
      mdl_ap = 256;
    end else begin
      dif = mdl_dms * 4 - mdl_dml;
      if (dif < 0) dif = -dif;
      if (y < 1536 || mdl_td || dif >= (mdl_dml >>> 3))
        mdl_ap = wrap16(mdl_ap + (('h200 - mdl_ap) >>> 4));
      else
        mdl_ap = wrap16(mdl_ap + ((-mdl_ap) >>> 4));
    end
  endtask

  task automatic codec_model_reset();
    mdl_encode = 1'b1;
    mdl_yl = 34816;
    mdl_yu = 544;
    mdl_dms = 0;
    mdl_dml = 0;
    mdl_ap = 0;
    mdl_td = 1'b0;
    for (int i = 0; i < 2; i++) begin
      mdl_a[i] = 0;
      mdl_pk[i] = 1'b0;
      mdl_sr[i] = 32;
    end
    for (int i = 0; i < ZeroTaps; i++) begin
      mdl_b[i] = 0;
      mdl_dq[i] = 32;
    end
  endtask

  // Run one item through the model and queue the result it must produce.
  task automatic predict_codec_item(input logic signed [15:0] smp, input logic [3:0] cw);
    int sezi, sez, pole, se, y, code, dq, sr, dqsez, sl;
    codec_result_t res;
    sezi = 0;
    for (int i = 0; i < ZeroTaps; i++) sezi += coef_times_hist(mdl_b[i] >>> 2, mdl_dq[i]);
    sezi = wrap16(sezi);
    sez = sezi >>> 1;
    pole = coef_times_hist(mdl_a[1] >>> 2, mdl_sr[1]) +
           coef_times_hist(mdl_a[0] >>> 2, mdl_sr[0]);
    // Estimate overflow: encode halves before the cut, decode after.
    if (mdl_encode) se = wrap16((sezi + pole) >>> 1);
    else se = wrap16(sezi + pole) >>> 1;
    y = wrap16(mixed_scale());
    if (mdl_encode) begin
      sl = int'(smp) >>> 2;
      code = code_from_diff(wrap16(sl - se), y);
    end else begin
      code = int'(cw);
    end
    dq = wrap16(diff_from_log(code[3], dq_log[code], y));
    sr = wrap16((dq < 0) ? se - (dq & 'h3FFF) : se + dq);
    dqsez = wrap16(sr - se + sez);
    adapt_state(y, scale_wt[code] * 32, rate_wt[code], dq, sr, dqsez);
    if (mdl_encode) begin
      res.code = code[3:0];
      res.pcm = 16'h0;
    end else begin
      res.code = 4'h0;
      res.pcm = {sr[13:0], 2'b00};
    end
    expected_results.push_back(res);
  endtask

  // Receiver stall pattern: driven at the falling edge, so the next rising
  // edge sees a settled out_stall.
  int stall_phase = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(20, 150);
      stall_mode = $urandom_range(0, 3);
    end
    stall_phase--;
    case (stall_mode)
      0: out_stall <= 1'b0;                          // free flow
      1: out_stall <= ($urandom_range(0, 2) == 0);   // light random stall
      2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy stall
      default: out_stall <= (stall_phase % 16) < 9;  // long periodic stall
    endcase
  end

  // Check on the value of out_stall that the rising edge will see.
  always @(posedge clk) begin
    codec_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: code %0d pcm %0d", code_out, pcm_out);
      end else begin
        exp_res = expected_results.pop_front();
        if (code_out !== exp_res.code || pcm_out !== exp_res.pcm) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: code exp %0d got %0d, pcm exp %0d got %0d",
                     results_seen, exp_res.code, code_out,
                     $signed(exp_res.pcm), pcm_out);
        end
      end
    end
  end

  // Send one item; return at the falling edge after it was taken, valid high.
  task automatic send_codec_item(input logic signed [15:0] smp, input logic [3:0] cw);
    if (burst_left == 0) begin
      // Gap between bursts, then pick the next burst length.
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid = 1'b1;
    pcm_sample = smp;
    code_in = cw;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_codec_item(smp, cw);
    items_sent++;
    if (mdl_encode) enc_items++;
    else dec_items++;
    @(negedge clk);
  endtask

  // Hold input until every expected result is in, then let the block settle.
  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_mode(input logic enc);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data = enc;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    mdl_encode = enc;
    mode_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] tone_sample(input int k, input real freq,
                                                     input real amp);
    real v;
    v = amp * $sin(6.283185307 * freq * k) + $urandom_range(0, 64) - 32;
    if (v > 32767.0) v = 32767.0;
    if (v < -32768.0) v = -32768.0;
    return 16'(int'(v));
  endfunction

  // Encode from reset: field extremes, sign edges, full-scale difference.
  task automatic test_encode_extremes();
    logic signed [15:0] pts[12] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
                                    -16'sh8000, 16'sh0001, -16'sh0001, 16'sh0003,
                                    -16'sh0004, 16'sh4000, -16'sh4000, 16'sh5555};
    foreach (pts[i]) send_codec_item(pts[i], 4'($urandom_range(0, 15)));
  endtask

  // Decode every code, then the largest and log-zero codes back to back.
  task automatic test_decode_codes();
    logic [3:0] tail[6] = '{4'd7, 4'd7, 4'd8, 4'd8, 4'd0, 4'd15};
    write_mode(1'b0);
    for (int c = 0; c < 16; c++) send_codec_item(16'($urandom), 4'(c));
    foreach (tail[i]) send_codec_item(16'($urandom), tail[i]);
  endtask

  // Encode: mostly tones (which drive the tone detector and predictor deep),
  // some noise and full-scale bursts.
  task automatic test_encode_random(input int count);
    int k, seg;
    real freq, amp;
    logic signed [15:0] s;
    write_mode(1'b1);
    k = 0;
    while (k < count) begin
      seg = $urandom_range(0, 9);
      freq = $urandom_range(5, 450) / 1000.0;
      amp = $urandom_range(100, 40000);
      for (int j = 0; j < $urandom_range(20, 90) && k < count; j++) begin
        if (seg < 7) s = tone_sample(j, freq, amp);
        else if (seg < 9) s = 16'($urandom);
        else s = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : -16'sh8000;
        send_codec_item(s, 4'($urandom));
        k++;
      end
      // Hold off around mid-stream until the block has nothing outstanding.
      if (k >= count / 2 && k - count / 2 < 90) drain_results();
    end
  endtask

  // Decode: random code runs and runs biased to the largest codes.
  task automatic test_decode_random(input int count);
    int k, seg;
    logic [3:0] c;
    logic [3:0] big[4] = '{4'd7, 4'd8, 4'd0, 4'd15};
    write_mode(1'b0);
    k = 0;
    while (k < count) begin
      seg = $urandom_range(0, 3);
      for (int j = 0; j < $urandom_range(10, 60) && k < count; j++) begin
        if (seg == 0) c = big[$urandom_range(0, 3)];
        else if (seg == 1) c = 4'(j[0] ? $urandom_range(0, 3) : $urandom_range(12, 15));
        else c = 4'($urandom);
        send_codec_item(16'($urandom), c);
        k++;
      end
    end
  endtask

  // Flip the mode several times with short runs in between; state carries over.
  task automatic test_mode_switches();
    for (int r = 0; r < 6; r++) begin
      write_mode(r[0]);
      for (int j = 0; j < 10; j++) send_codec_item(16'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    pcm_sample = '0;
    code_in = '0;
    codec_model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_encode_extremes();
    test_decode_codes();
    test_encode_random(640);
    test_decode_random(620);
    test_mode_switches();

    drain_results();
    $display("covered %0d items (%0d encoded, %0d decoded), %0d mode writes",
             items_sent, enc_items, dec_items, mode_writes);
    $display("results checked %0d, mismatches %0d", results_seen, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: g726_32k_adpcm_codec_unit.f
src/g726_pkg.sv
src/g726_32k_adpcm_codec_unit.sv
test/tb_top.sv
